### design/tendency_utility_argmax_macros.svh
// Assertion helpers included by the top-level scorer.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TENDENCY_UTILITY_ARGMAX_MACROS_SVH
`define TENDENCY_UTILITY_ARGMAX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TUA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TUA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tua_pkg.sv
package tua_pkg;

    localparam int unsigned WEIGHT_BITS_DEFAULT = 16;
    localparam int unsigned COEF_W              = 16;
    localparam int unsigned UTIL_W              = 32;
    localparam int unsigned IDX_W               = 4;
    localparam int unsigned CFG_IDX_W           = 3;
    localparam int unsigned COEF_COUNT          = 6;

    // Register indexes of the coefficient bank.
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_NEG_INC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_NEG_DEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_POS_INC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_POS_DEC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_TO_POS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TO_NEG   = 3'd5;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [COEF_COUNT-1:0]   t_coef_bank;

    localparam t_coef COEF_RESET = t_coef'(1);
    localparam logic signed [UTIL_W-1:0] BEST_RESET = -32'sd1;

    // Bookkeeping that travels alongside each dimension's product.
    typedef struct packed {
        logic [IDX_W-1:0] class_index;
        logic [IDX_W-1:0] item_index;
        logic             last_dim;
        logic             last_candidate;
    } t_tag;

endpackage

### design/tua_if.sv
interface tua_in_if #(
    parameter int unsigned WEIGHT_BITS = tua_pkg::WEIGHT_BITS_DEFAULT
) ();
    logic                        valid;
    logic                        ready;
    logic [tua_pkg::IDX_W-1:0]   class_index;
    logic [tua_pkg::IDX_W-1:0]   item_index;
    logic [WEIGHT_BITS-1:0]      dim_capacity;
    logic [WEIGHT_BITS-1:0]      current_weight;
    logic [WEIGHT_BITS-1:0]      candidate_weight;
    logic                        last_dim;
    logic                        last_candidate;

    modport source (
        output valid, class_index, item_index, dim_capacity, current_weight,
               candidate_weight, last_dim, last_candidate,
        input  ready
    );
    modport sink (
        input  valid, class_index, item_index, dim_capacity, current_weight,
               candidate_weight, last_dim, last_candidate,
        output ready
    );
endinterface

interface tua_out_if ();
    logic                               valid;
    logic                               ready;
    logic signed [tua_pkg::UTIL_W-1:0]  utility;
    logic                               best_found;
    logic [tua_pkg::IDX_W-1:0]          best_class;
    logic [tua_pkg::IDX_W-1:0]          best_item;
    logic                               search_done;

    modport source (
        output valid, utility, best_found, best_class, best_item, search_done,
        input  ready
    );
    modport sink (
        input  valid, utility, best_found, best_class, best_item, search_done,
        output ready
    );
endinterface

interface tua_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [tua_pkg::CFG_IDX_W-1:0]    index;
    logic [tua_pkg::COEF_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/tua_score.sv
module tua_score #(
    parameter int unsigned WEIGHT_BITS = tua_pkg::WEIGHT_BITS_DEFAULT,
    parameter int unsigned PROD_W      = tua_pkg::COEF_W + WEIGHT_BITS + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tua_pkg::t_tag               i_tag,
    input  logic [WEIGHT_BITS-1:0]      i_capacity,
    input  logic [WEIGHT_BITS-1:0]      i_current,
    input  logic [WEIGHT_BITS-1:0]      i_candidate,
    input  tua_pkg::t_coef_bank         i_coef,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tua_pkg::t_tag               o_tag,
    output logic signed [PROD_W-1:0]    o_prod
);

    logic                       r_s1_valid;
    tua_pkg::t_tag              r_s1_tag;
    logic [WEIGHT_BITS-1:0]     r_cap;
    logic [WEIGHT_BITS-1:0]     r_cur;
    logic [WEIGHT_BITS-1:0]     r_cand;
    logic                       r_s2_valid;
    tua_pkg::t_tag              r_s2_tag;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   n_prod;

    logic                       w_s1_free;
    logic                       w_s2_free;
    logic signed [WEIGHT_BITS:0] w_slack_cur;
    logic signed [WEIGHT_BITS:0] w_slack_cand;
    logic signed [WEIGHT_BITS:0] w_diff;
    logic [WEIGHT_BITS-1:0]     w_mag;
    logic                       w_cur_neg;
    logic                       w_cur_pos;
    logic                       w_cand_neg;
    logic                       w_cand_pos;
    logic                       w_cur_ge;
    tua_pkg::t_coef             w_coef;
    logic signed [PROD_W-1:0]   w_coef_x;
    logic signed [PROD_W-1:0]   w_mag_x;

    assign w_s2_free = !r_s2_valid || i_ready;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_ready   = w_s1_free;

    assign w_slack_cur  = $signed({1'b0, r_cap}) - $signed({1'b0, r_cur});
    assign w_slack_cand = $signed({1'b0, r_cap}) - $signed({1'b0, r_cand});
    // The slack difference reduces to the weight difference.
    assign w_diff = $signed({1'b0, r_cand}) - $signed({1'b0, r_cur});
    assign w_mag  = w_diff[WEIGHT_BITS] ? WEIGHT_BITS'(-w_diff) : w_diff[WEIGHT_BITS-1:0];

    assign w_cur_neg  = w_slack_cur[WEIGHT_BITS];
    assign w_cur_pos  = !w_slack_cur[WEIGHT_BITS] && (w_slack_cur != '0);
    assign w_cand_neg = w_slack_cand[WEIGHT_BITS];
    assign w_cand_pos = !w_slack_cand[WEIGHT_BITS] && (w_slack_cand != '0);
    assign w_cur_ge   = (r_cand >= r_cur);

    // A zero slack selects no coefficient, so the product adds nothing.
    always_comb begin
        priority if (w_cur_neg && w_cand_neg) begin
            w_coef = w_cur_ge ? i_coef[tua_pkg::CFG_BOTH_NEG_INC]
                              : i_coef[tua_pkg::CFG_BOTH_NEG_DEC];
        end else if (w_cur_pos && w_cand_pos) begin
            w_coef = w_cur_ge ? i_coef[tua_pkg::CFG_BOTH_POS_INC]
                              : i_coef[tua_pkg::CFG_BOTH_POS_DEC];
        end else if (w_cur_neg && w_cand_pos) begin
            w_coef = i_coef[tua_pkg::CFG_NEG_TO_POS];
        end else if (w_cur_pos && w_cand_neg) begin
            w_coef = i_coef[tua_pkg::CFG_POS_TO_NEG];
        end else begin
            w_coef = '0;
        end
    end

    assign w_coef_x = PROD_W'(w_coef);
    assign w_mag_x  = PROD_W'({1'b0, w_mag});
    assign n_prod   = w_coef_x * w_mag_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_s1_free) begin
            r_s1_tag <= i_tag;
            r_cap    <= i_capacity;
            r_cur    <= i_current;
            r_cand   <= i_candidate;
        end
        if (r_s1_valid && w_s2_free) begin
            r_s2_tag <= r_s1_tag;
            r_prod   <= n_prod;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_tag   = r_s2_tag;
    assign o_prod  = r_prod;

endmodule

### design/tua_track.sv
module tua_track #(
    parameter int unsigned PROD_W = tua_pkg::COEF_W + tua_pkg::WEIGHT_BITS_DEFAULT + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tua_pkg::t_tag                       i_tag,
    input  logic signed [PROD_W-1:0]            i_prod,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tua_pkg::UTIL_W-1:0]   o_utility,
    output logic                                o_best_found,
    output logic [tua_pkg::IDX_W-1:0]           o_best_class,
    output logic [tua_pkg::IDX_W-1:0]           o_best_item,
    output logic                                o_search_done
);

    localparam int unsigned UW    = tua_pkg::UTIL_W;
    localparam int unsigned SUM_W = ((PROD_W > UW) ? PROD_W : UW) + 1;
    localparam logic signed [UW-1:0] UTIL_MAX = $signed({1'b0, {(UW-1){1'b1}}});
    localparam logic signed [UW-1:0] UTIL_MIN = $signed({1'b1, {(UW-1){1'b0}}});
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(UTIL_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(UTIL_MIN);

    logic signed [UW-1:0]           r_sum;
    logic signed [UW-1:0]           r_best_util;
    logic [tua_pkg::IDX_W-1:0]      r_best_class;
    logic [tua_pkg::IDX_W-1:0]      r_best_item;
    logic                           r_best_valid;
    logic                           r_out_valid;
    logic signed [UW-1:0]           r_utility;
    logic                           r_found;
    logic [tua_pkg::IDX_W-1:0]      r_out_class;
    logic [tua_pkg::IDX_W-1:0]      r_out_item;
    logic                           r_done;

    logic signed [UW-1:0]           n_best_util;
    logic [tua_pkg::IDX_W-1:0]      n_best_class;
    logic [tua_pkg::IDX_W-1:0]      n_best_item;
    logic                           n_best_valid;

    logic                           w_slot_free;
    logic                           w_fire;
    logic signed [SUM_W-1:0]        w_wide;
    logic signed [UW-1:0]           w_sat;
    logic                           w_better;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_ready     = !i_tag.last_dim || w_slot_free;
    assign w_fire      = i_valid && o_ready;

    assign w_wide = SUM_W'(r_sum) + SUM_W'(i_prod);

    always_comb begin
        priority if (w_wide > SAT_HI) begin
            w_sat = UTIL_MAX;
        end else if (w_wide < SAT_LO) begin
            w_sat = UTIL_MIN;
        end else begin
            w_sat = w_wide[UW-1:0];
        end
    end

    // Ties keep the earlier candidate.
    assign w_better     = (w_sat > r_best_util);
    assign n_best_util  = w_better ? w_sat : r_best_util;
    assign n_best_class = w_better ? i_tag.class_index : r_best_class;
    assign n_best_item  = w_better ? i_tag.item_index : r_best_item;
    assign n_best_valid = w_better || r_best_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_best_util  <= tua_pkg::BEST_RESET;
            r_best_class <= '0;
            r_best_item  <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire && i_tag.last_dim) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                if (!i_tag.last_dim) begin
                    r_sum <= w_sat;
                end else begin
                    r_sum <= '0;
                    if (i_tag.last_candidate) begin
                        r_best_util  <= tua_pkg::BEST_RESET;
                        r_best_class <= '0;
                        r_best_item  <= '0;
                        r_best_valid <= 1'b0;
                    end else begin
                        r_best_util  <= n_best_util;
                        r_best_class <= n_best_class;
                        r_best_item  <= n_best_item;
                        r_best_valid <= n_best_valid;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_tag.last_dim) begin
            r_utility   <= w_sat;
            r_found     <= n_best_valid;
            r_out_class <= n_best_class;
            r_out_item  <= n_best_item;
            r_done      <= i_tag.last_candidate;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_utility     = r_utility;
    assign o_best_found  = r_found;
    assign o_best_class  = r_out_class;
    assign o_best_item   = r_out_item;
    assign o_search_done = r_done;

endmodule

### design/tendency_utility_argmax.sv
// Tendency-utility scorer with a running best-candidate tracker.
// i_in carries one dimension of one candidate per transfer: the capacity, the weight of the
// class's current item and the candidate's weight, plus last_dim and last_candidate marks.
// o_out carries one result per candidate, made on the transfer that has last_dim set: the
// saturated utility and the best class and item seen so far in this search.
// i_cfg writes the six signed coefficients; it is always ready and should only be used while
// the block is idle. An index beyond the bank is dropped.
// Throughput is one dimension per cycle while i_in.ready stays high. The path is an input
// register, a product register (one 16-bit coefficient times the magnitude of the weight
// difference) and the result register.
// When o_out stalls, dimensions that end no candidate keep flowing; a last dimension waits in
// the product register, and i_in.ready drops only once both internal stages are full.
// Reset clears the pipeline, the accumulator, and the best tracking (best utility minus one,
// no candidate found); all coefficients return to one.
module tendency_utility_argmax #(
    parameter int unsigned WEIGHT_BITS = tua_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tua_in_if.sink     i_in,
    tua_out_if.source  o_out,
    tua_cfg_if.sink    i_cfg
);

`include "tendency_utility_argmax_macros.svh"

    localparam int unsigned PROD_W = tua_pkg::COEF_W + WEIGHT_BITS + 1;

    tua_pkg::t_coef_bank        r_coef;
    tua_pkg::t_tag              w_in_tag;
    tua_pkg::t_tag              w_prod_tag;
    logic                       w_prod_valid;
    logic                       w_trk_ready;
    logic signed [PROD_W-1:0]   w_prod;

    // Coefficient bank: a write lands directly in its register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= {tua_pkg::COEF_COUNT{tua_pkg::COEF_RESET}};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tua_pkg::CFG_BOTH_NEG_INC: r_coef[tua_pkg::CFG_BOTH_NEG_INC] <= i_cfg.data;
                tua_pkg::CFG_BOTH_NEG_DEC: r_coef[tua_pkg::CFG_BOTH_NEG_DEC] <= i_cfg.data;
                tua_pkg::CFG_BOTH_POS_INC: r_coef[tua_pkg::CFG_BOTH_POS_INC] <= i_cfg.data;
                tua_pkg::CFG_BOTH_POS_DEC: r_coef[tua_pkg::CFG_BOTH_POS_DEC] <= i_cfg.data;
                tua_pkg::CFG_NEG_TO_POS:   r_coef[tua_pkg::CFG_NEG_TO_POS]   <= i_cfg.data;
                tua_pkg::CFG_POS_TO_NEG:   r_coef[tua_pkg::CFG_POS_TO_NEG]   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign w_in_tag.class_index    = i_in.class_index;
    assign w_in_tag.item_index     = i_in.item_index;
    assign w_in_tag.last_dim       = i_in.last_dim;
    assign w_in_tag.last_candidate = i_in.last_candidate;

    // Slack classification and the coefficient product.
    tua_score #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .PROD_W      (PROD_W)
    ) u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_tag       (w_in_tag),
        .i_capacity  (i_in.dim_capacity),
        .i_current   (i_in.current_weight),
        .i_candidate (i_in.candidate_weight),
        .i_coef      (r_coef),
        .o_valid     (w_prod_valid),
        .i_ready     (w_trk_ready),
        .o_tag       (w_prod_tag),
        .o_prod      (w_prod)
    );

    // Saturating accumulation, the strict-greater best tracker and the result register.
    tua_track #(
        .PROD_W (PROD_W)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_prod_valid),
        .o_ready       (w_trk_ready),
        .i_tag         (w_prod_tag),
        .i_prod        (w_prod),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_utility     (o_out.utility),
        .o_best_found  (o_out.best_found),
        .o_best_class  (o_out.best_class),
        .o_best_item   (o_out.best_item),
        .o_search_done (o_out.search_done)
    );

    // A last dimension taken by the tracker must show up as a result in the next cycle.
    `TUA_ASSERT_NEXT(a_last_dim_gives_result, w_prod_valid && w_trk_ready && w_prod_tag.last_dim, o_out.valid, "last dimension produced no result")

    // Without a best candidate the reported class and item stay at their cleared values.
    `TUA_ASSERT_SAME(a_no_best_is_clear, o_out.valid && !o_out.best_found, (o_out.best_class == '0) && (o_out.best_item == '0), "best index set without a best candidate")

    // The input side only stalls when the product stage is full and cannot drain.
    `TUA_ASSERT_SAME(a_stall_only_when_full, !i_in.ready, w_prod_valid && !w_trk_ready, "input stalled while the pipeline could move")

endmodule
